// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Sizes, operation and status codes, request and response formats and the
// wrapping index helpers of the deque; its entry store uses the sizes and index type.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    status_t                   status;
    logic                      is_empty;
    logic                      is_full;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
  } out_rsp_t;

  function automatic idx_t idx_next(input idx_t i);
    return (i == IDX_LAST) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? IDX_LAST : i - idx_t'(1);
  endfunction

endpackage

// ===== rtl/cdq_store.sv =====
// ----------------------------------------------------------------------------
// cdq_store: entry store of the circular deque
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module cdq_store
  import cdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      wr_en,
  input  idx_t                      wr_addr,
  input  logic signed [DATA_W-1:0]  wr_data,
  input  logic                      rd_en,
  input  idx_t                      rd_addr,
  output logic signed [DATA_W-1:0]  rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit values
// Each request pushes or pops at the front or the rear of a circular store.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid/in_ready with in_data (op, value); every request
// produces exactly one response on out_valid/out_ready with out_data (status,
// empty and full flags, front and rear values after the operation).
// Pushes, refused requests and the pop of the last entry answer in the cycle
// after acceptance and allow a new request every cycle while responses are
// taken. A pop that leaves entries behind reads the new front or rear entry
// from the store's registered read port, so its response passes through the
// read register and the output register; no new request is taken until it
// is loaded. The response sits in an output register; the next request is
// accepted while it waits, as long as it is taken in the same cycle or the
// register is free. A stalled receiver holds off new requests once the
// register is occupied. Reset empties the deque and clears the response
// valid flag; the store is not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_req_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_rsp_t  out_data
);

  state_t state_r, state_nxt;
  idx_t   head_r, head_nxt;
  idx_t   tail_r, tail_nxt;
  logic   empty_r, empty_nxt;
  logic   pend_front_r;
  logic   out_valid_r;
  out_rsp_t out_r;
  logic signed [DATA_W-1:0] front_r, front_nxt;
  logic signed [DATA_W-1:0] rear_r, rear_nxt;

  logic     in_fire, out_free;
  logic     need_read, load_now, load_read;
  status_t  status_acc;
  logic     wr_en, rd_en;
  idx_t     wr_addr, rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] front_rd, rear_rd;
  logic     full_now, full_reg;

  cdq_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    status_acc = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    need_read  = 1'b0;
    if (in_fire) begin
      unique case (in_data.op) inside
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (full_reg) begin
            status_acc = ST_OVER;
          end else if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = '0;
            front_nxt = in_data.value;
            rear_nxt  = in_data.value;
          end else if (in_data.op == OP_PUSH_FRONT) begin
            head_nxt  = idx_prev(head_r);
            wr_en     = 1'b1;
            wr_addr   = idx_prev(head_r);
            front_nxt = in_data.value;
          end else begin
            tail_nxt  = idx_next(tail_r);
            wr_en     = 1'b1;
            wr_addr   = idx_next(tail_r);
            rear_nxt  = in_data.value;
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (empty_r) begin
            status_acc = ST_UNDER;
          end else if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (in_data.op == OP_POP_FRONT) begin
            head_nxt  = idx_next(head_r);
            rd_en     = 1'b1;
            rd_addr   = idx_next(head_r);
            need_read = 1'b1;
          end else begin
            tail_nxt  = idx_prev(tail_r);
            rd_en     = 1'b1;
            rd_addr   = idx_prev(tail_r);
            need_read = 1'b1;
          end
        end
        default: begin
          status_acc = ST_DONE;
        end
      endcase
    end
  end

  assign full_reg = !empty_r && (head_r == idx_next(tail_r));
  assign full_now = !empty_nxt && (head_nxt == idx_next(tail_nxt));

  assign front_rd = pend_front_r ? rd_data : front_r;
  assign rear_rd  = pend_front_r ? rear_r : rd_data;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && need_read) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    load_read = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
      end
      S_READ: begin
        load_read = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign load_now = in_fire && !need_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      if (load_now || load_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_front_r <= (in_data.op == OP_POP_FRONT);
    end
    if (load_read) begin
      front_r <= front_rd;
      rear_r  <= rear_rd;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
    if (load_now) begin
      out_r.status      <= status_acc;
      out_r.is_empty    <= empty_nxt;
      out_r.is_full     <= full_now;
      out_r.front_value <= empty_nxt ? '0 : front_nxt;
      out_r.rear_value  <= empty_nxt ? '0 : rear_nxt;
    end else if (load_read) begin
      out_r.status      <= ST_DONE;
      out_r.is_empty    <= empty_r;
      out_r.is_full     <= full_reg;
      out_r.front_value <= empty_r ? '0 : front_rd;
      out_r.rear_value  <= empty_r ? '0 : rear_rd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
